// ----- design/frustum_box_sphere_cull_macros.svh -----
// Assertion macros for the frustum cull block.
// Used by the modules that carry concurrent checks; relies on clk_i and rst_ni.
`ifndef FRUSTUM_BOX_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_BOX_SPHERE_CULL_MACROS_SVH
`ifndef SYNTH
`define FBSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fbsc assertion failed");
`define FBSC_ASSERT_IMPL(lbl, ante, cons) \
  `FBSC_ASSERT(lbl, (ante) |-> (cons))
`else
`define FBSC_ASSERT(lbl, prop)
`define FBSC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// ----- design/fbsc_pkg.sv -----
// Shared types and constants for the frustum cull block.
// No dependencies; used by fbsc_plane_eval and frustum_box_sphere_cull.
package fbsc_pkg;

  localparam int unsigned NumPlanesDef = 6;

  localparam logic [1:0] FuncLoad   = 2'd0;
  localparam logic [1:0] FuncBox    = 2'd1;
  localparam logic [1:0] FuncSphere = 2'd2;

  localparam int unsigned SumW = 66;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] d;
  } plane_t;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic vld;
    logic last;
    logic below;
  } res_t;

endpackage

// ----- design/fbsc_plane_eval.sv -----
// One plane per cycle: corner pick and products (registered), then exact sum and sign.
// Depends on fbsc_pkg.
module fbsc_plane_eval import fbsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  plane_t             plane_i,
  input  logic               is_box_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic signed [31:0] qx_i,
  input  logic signed [31:0] qy_i,
  input  logic signed [31:0] qz_i,
  input  logic signed [31:0] s_i,
  output res_t               res_o
);

  logic signed [31:0] vx, vy, vz;
  logic signed [63:0] prod_x_d, prod_y_d, prod_z_d;
  logic signed [63:0] prod_x_q, prod_y_q, prod_z_q;
  logic signed [32:0] ofs_d, ofs_q;
  logic signed [SumW-1:0] sum;
  ctl_t ctl_q;

  // positive vertex: upper corner where the normal component is positive (boxes; spheres use p)
  always_comb begin
    vx = (is_box_i && (plane_i.nx > 0)) ? qx_i : px_i;
    vy = (is_box_i && (plane_i.ny > 0)) ? qy_i : py_i;
    vz = (is_box_i && (plane_i.nz > 0)) ? qz_i : pz_i;
    prod_x_d = plane_i.nx * vx;
    prod_y_d = plane_i.ny * vy;
    prod_z_d = plane_i.nz * vz;
    ofs_d = 33'(plane_i.d) + 33'(s_i);
  end

  always_ff @(posedge clk_i) begin
    prod_x_q <= prod_x_d;
    prod_y_q <= prod_y_d;
    prod_z_q <= prod_z_d;
    ofs_q    <= ofs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // offset term scaled to Q32.32; width holds three full products without wrap
  assign sum = SumW'(prod_x_q) + SumW'(prod_y_q) + SumW'(prod_z_q)
             + SumW'($signed({ofs_q, 16'b0}));

  assign res_o.vld   = ctl_q.vld;
  assign res_o.last  = ctl_q.last;
  assign res_o.below = sum[SumW-1];

endmodule

// ----- design/frustum_box_sphere_cull.sv -----
// A box or sphere test reports on done_o once the last plane has left the evaluator;
// busy stays high until the result cycle, so a new test is not accepted before the last one reports.
// The plane memory is read one entry per cycle; each entry feeds the plane evaluator.
// Loads and unused codes leave the block idle and give no result.
// Reset (asynchronous, active low) returns to idle and marks every plane as zero.
`include "frustum_box_sphere_cull_macros.svh"
module frustum_box_sphere_cull import fbsc_pkg::*; #(
  parameter int unsigned NUM_PLANES = NumPlanesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [2:0]         plane_index_i,
  input  logic signed [31:0] px_i,
  input  logic signed [31:0] py_i,
  input  logic signed [31:0] pz_i,
  input  logic signed [31:0] qx_i,
  input  logic signed [31:0] qy_i,
  input  logic signed [31:0] qz_i,
  input  logic signed [31:0] scalar_i,
  output logic               done_o,
  output logic               visible_o
);

  localparam int unsigned IdxW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_PLANES - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic accept, is_test, do_load, issue;

  plane_t mem_q [NUM_PLANES];
  logic [NUM_PLANES-1:0] ent_vld_q;
  plane_t rdata_q, plane_rd;
  logic rdata_vld_q;
  ctl_t rd_ctl_q, rd_ctl_d;

  logic is_box_q;
  logic signed [31:0] px_q, py_q, pz_q, qx_q, qy_q, qz_q, s_q;
  logic culled_q, culled_d;
  logic done_q, done_d, visible_q, visible_d;
  res_t res;

  assign busy    = (state_q != StIdle);
  assign accept  = start && !busy;
  assign is_test = (func_i == FuncBox) || (func_i == FuncSphere);
  assign do_load = accept && (func_i == FuncLoad) &&
                   ({2'b0, plane_index_i} < 5'(NUM_PLANES));
  assign issue   = (state_q == StRead);

  // Loads only happen while idle, so a write never overlaps a read sweep.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem_q[IdxW'(plane_index_i)] <= '{nx: px_i, ny: py_i, nz: pz_i, d: scalar_i};
    end
    if (issue) begin
      rdata_q <= mem_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q   <= '0;
      rdata_vld_q <= 1'b0;
    end else begin
      if (do_load) begin
        ent_vld_q[IdxW'(plane_index_i)] <= 1'b1;
      end
      if (issue) begin
        rdata_vld_q <= ent_vld_q[cnt_q];
      end
    end
  end

  // never-loaded planes read as zero
  assign plane_rd = rdata_vld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (accept && is_test) begin
      is_box_q <= (func_i == FuncBox);
      px_q <= px_i;
      py_q <= py_i;
      pz_q <= pz_i;
      qx_q <= qx_i;
      qy_q <= qy_i;
      qz_q <= qz_i;
      s_q  <= scalar_i;
    end
  end

  fbsc_plane_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (rd_ctl_q),
    .plane_i  (plane_rd),
    .is_box_i (is_box_q),
    .px_i     (px_q),
    .py_i     (py_q),
    .pz_i     (pz_q),
    .qx_i     (qx_q),
    .qy_i     (qy_q),
    .qz_i     (qz_q),
    .s_i      (s_q),
    .res_o    (res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    rd_ctl_d  = '0;
    culled_d  = culled_q;
    done_d    = 1'b0;
    visible_d = visible_q;
    if (res.vld) begin
      culled_d = culled_q | res.below;
    end
    case (state_q)
      StIdle: begin
        if (accept && is_test) begin
          state_d  = StRead;
          cnt_d    = '0;
          culled_d = 1'b0;
        end
      end
      StRead: begin
        rd_ctl_d.vld  = 1'b1;
        rd_ctl_d.last = (cnt_q == LastIdx);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (res.vld && res.last) begin
          state_d   = StIdle;
          done_d    = 1'b1;
          visible_d = !(culled_q | res.below);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rd_ctl_q  <= '0;
      culled_q  <= 1'b0;
      done_q    <= 1'b0;
      visible_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_ctl_q  <= rd_ctl_d;
      culled_q  <= culled_d;
      done_q    <= done_d;
      visible_q <= visible_d;
    end
  end

  assign done_o    = done_q;
  assign visible_o = visible_q;

  `FBSC_ASSERT_IMPL(a_done_when_idle, done_o, !busy)
  `FBSC_ASSERT_IMPL(a_done_single, done_o, ##1 !done_o)
  `FBSC_ASSERT_IMPL(a_test_goes_busy, start && !busy && is_test, ##1 busy)
  `FBSC_ASSERT_IMPL(a_eval_only_busy, res.vld, busy)
  `FBSC_ASSERT_IMPL(a_no_load_when_busy, do_load, state_q == StIdle)

endmodule
